[design/lfsta_pkg.sv]
package lfsta_pkg;

  localparam int TIME_W          = 48;
  localparam int WEIGHT_W        = 18;
  localparam int DUR_W           = 16;
  localparam int SID_W           = 4;
  localparam int ACT_W           = 5;
  localparam int NUM_SERVERS_DEF = 16;

  localparam logic [ACT_W-1:0]  ACT_RESET = 5'd16;
  localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TASK = 1'b1;

  typedef struct packed {
    logic load;        // write weight table entry
    logic init;        // capture task, begin earliest-free scan
    logic min_step;    // one server of the earliest-free scan
    logic start_calc;  // resolve start time, begin pick scan
    logic pick_step;   // one server of the lightest-free scan
    logic commit;      // update server state, emit result
  } cmd_t;

  typedef struct packed {
    logic idx_last;    // scan index is at the last active server
  } status_t;

endpackage

[design/lfsta_ctrl.sv]
module lfsta_ctrl
  import lfsta_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  logic    in_kind,
  input  status_t status,
  output logic    busy,
  output cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MIN    = 3'd1;
  localparam logic [2:0] S_START  = 3'd2;
  localparam logic [2:0] S_PICK   = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  logic [2:0] st_r;
  logic [2:0] st_nxt;

  assign busy = (st_r != S_IDLE);

  always_comb begin
    st_nxt = st_r;
    cmd    = '0;
    case (st_r)
      S_IDLE: begin
        if (start) begin
          if (in_kind == KIND_TASK) begin
            cmd.init = 1'b1;
            st_nxt   = S_MIN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_MIN: begin
        cmd.min_step = 1'b1;
        if (status.idx_last) st_nxt = S_START;
      end
      S_START: begin
        cmd.start_calc = 1'b1;
        st_nxt         = S_PICK;
      end
      S_PICK: begin
        cmd.pick_step = 1'b1;
        if (status.idx_last) st_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        st_nxt     = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

[design/lfsta_dp.sv]
module lfsta_dp
  import lfsta_pkg::*;
#(
  parameter int NUM_SERVERS = NUM_SERVERS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic                cfg_we,
  input  logic [ACT_W-1:0]    cfg_data,
  input  logic [SID_W-1:0]    in_server_id,
  input  logic [WEIGHT_W-1:0] in_weight,
  input  logic [DUR_W-1:0]    in_duration,
  output logic                out_valid,
  output logic [SID_W-1:0]    out_assigned_server,
  output logic [TIME_W-1:0]   out_start_time
);

  localparam int IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;

  logic [TIME_W-1:0]   busy_r [NUM_SERVERS];
  logic [WEIGHT_W-1:0] weight_r [NUM_SERVERS];

  logic [ACT_W-1:0]    active_r;
  logic [TIME_W-1:0]   last_start_r;
  logic [TIME_W-1:0]   task_cnt_r;
  logic [IDX_W-1:0]    idx_r;
  logic [TIME_W-1:0]   earliest_r;
  logic [TIME_W-1:0]   start_r;
  logic [IDX_W-1:0]    pick_r;
  logic [WEIGHT_W-1:0] best_w_r;
  logic                found_r;
  logic [DUR_W-1:0]    dur_r;
  logic                out_valid_r;
  logic [SID_W-1:0]    out_srv_r;
  logic [TIME_W-1:0]   out_start_r;

  logic [6:0]          act_lim;
  logic [IDX_W-1:0]    act_last;
  logic [TIME_W-1:0]   cur_busy;
  logic [WEIGHT_W-1:0] cur_w;
  logic [TIME_W-1:0]   lo_bound;
  logic [TIME_W-1:0]   start_val;
  logic [TIME_W:0]     fin_sum;
  logic [TIME_W-1:0]   finish;
  logic                sid_ok;

  // Last active index: zero count acts as one, large counts clamp
  always_comb begin
    if (active_r == '0) begin
      act_lim = 7'd0;
    end else if ({2'b00, active_r} > 7'(NUM_SERVERS)) begin
      act_lim = 7'(NUM_SERVERS - 1);
    end else begin
      act_lim = {2'b00, active_r} - 7'd1;
    end
  end
  assign act_last        = act_lim[IDX_W-1:0];
  assign status.idx_last = (idx_r == act_last);

  assign cur_busy  = busy_r[idx_r];
  assign cur_w     = weight_r[idx_r];
  assign lo_bound  = (task_cnt_r > last_start_r) ? task_cnt_r : last_start_r;
  assign start_val = (earliest_r > lo_bound) ? earliest_r : lo_bound;
  assign fin_sum   = {1'b0, start_r} + {{(TIME_W + 1 - DUR_W){1'b0}}, dur_r};
  assign finish    = fin_sum[TIME_W] ? TIME_MAX : fin_sum[TIME_W-1:0];
  assign sid_ok    = ({{(32 - SID_W){1'b0}}, in_server_id} < 32'(NUM_SERVERS));

  always_ff @(posedge clk) begin
    if (cmd.load && sid_ok) begin
      weight_r[IDX_W'(in_server_id)] <= in_weight;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SERVERS; i++) busy_r[i] <= '0;
      active_r     <= ACT_RESET;
      last_start_r <= '0;
      task_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
      if (cfg_we) active_r <= cfg_data;
      if (cmd.commit) begin
        busy_r[pick_r] <= finish;
        last_start_r   <= start_r;
        if (task_cnt_r != TIME_MAX) task_cnt_r <= task_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      dur_r      <= in_duration;
      idx_r      <= '0;
      earliest_r <= TIME_MAX;
    end
    if (cmd.min_step) begin
      if (cur_busy < earliest_r) earliest_r <= cur_busy;
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.start_calc) begin
      start_r <= start_val;
      idx_r   <= '0;
      found_r <= 1'b0;
    end
    if (cmd.pick_step) begin
      if (cur_busy <= start_r && (!found_r || cur_w < best_w_r)) begin
        pick_r   <= idx_r;
        best_w_r <= cur_w;
        found_r  <= 1'b1;
      end
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.commit) begin
      out_srv_r   <= SID_W'(pick_r);
      out_start_r <= start_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_assigned_server = out_srv_r;
  assign out_start_time      = out_start_r;

`ifndef NO_ASSERTIONS
  a_strobe_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(cmd.commit))
    else $error("result strobe without commit");

  a_pick_is_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (busy_r[pick_r] <= start_r) && found_r)
    else $error("chosen server busy at start time");

  a_start_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> last_start_r >= $past(last_start_r))
    else $error("start time went backwards");

  a_start_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_calc |=> start_r >= $past(earliest_r) && start_r >= $past(task_cnt_r))
    else $error("start time below its bounds");
`endif

endmodule

[design/lightest_free_server_task_assigner.sv]
// Channel   | Ports                                           | Transaction
// input     | start, busy, in_kind, in_server_id, in_weight,  | start && !busy
//           | in_duration                                     |
// result    | out_valid, out_assigned_server, out_start_time  | out_valid, one cycle
// config    | cfg_we, cfg_data                                | cfg_we
//
// A load is written straight from idle; busy stays low.
// A task holds busy while it steps one server at a time, N the active server count,
// through the earliest-free and lightest-free scans, plus start resolve and commit.
// The result strobes in the first cycle busy is low again, registered from the commit.
// Synchronous active-low reset frees all servers, zeroes time and task counter.
// The receiver cannot stall; each result is shown for exactly one cycle.
module lightest_free_server_task_assigner
  import lfsta_pkg::*;
#(
  parameter int NUM_SERVERS = NUM_SERVERS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_kind,
  input  logic [SID_W-1:0]    in_server_id,
  input  logic [WEIGHT_W-1:0] in_weight,
  input  logic [DUR_W-1:0]    in_duration,
  output logic                out_valid,
  output logic [SID_W-1:0]    out_assigned_server,
  output logic [TIME_W-1:0]   out_start_time,
  input  logic                cfg_we,
  input  logic [ACT_W-1:0]    cfg_data
);

  cmd_t    cmd;
  status_t status;

  lfsta_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .status  (status),
    .busy    (busy),
    .cmd     (cmd)
  );

  lfsta_dp #(
    .NUM_SERVERS (NUM_SERVERS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .cfg_we              (cfg_we),
    .cfg_data            (cfg_data),
    .in_server_id        (in_server_id),
    .in_weight           (in_weight),
    .in_duration         (in_duration),
    .out_valid           (out_valid),
    .out_assigned_server (out_assigned_server),
    .out_start_time      (out_start_time)
  );

endmodule
